/* design/cfa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_pkg
// Shared types and constants of the contiguous fit allocator.
// ----------------------------------------------------------------------------
package cfa_pkg;

    localparam int DefMemUnits = 128;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic [1:0] OUT_LOADED  = 2'd0;
    localparam logic [1:0] OUT_EVICTED = 2'd1;
    localparam logic [1:0] OUT_REJECT  = 2'd2;

    localparam logic [0:0] REG_POLICY = 1'd0;
    localparam logic [0:0] REG_LIMIT  = 1'd1;

    localparam logic [3:0] SWAP_LIMIT_RST = 4'd3;
    localparam logic [3:0] SWAP_MAX       = 4'd15;

    // Command issued to the cell row by the controller.
    typedef struct packed {
        logic scan;   // shift the map one cell toward the head
        logic mark;   // apply the range update when not shifting
        logic value;  // value written into the range
    } cfa_row_cmd_t;

endpackage

/* design/cfa_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_cell
// One unit of the free map: holds its used bit and passes it to its neighbor.
// ----------------------------------------------------------------------------
module cfa_cell
    import cfa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfa_row_cmd_t cmd,
    input  logic         in_range,
    input  logic         shift_in,
    output logic         bit_out
);

    logic used_reg;
    logic used_next;

    always_comb
    begin
        used_next = used_reg;
        if (cmd.scan)
        begin
            used_next = shift_in;
        end
        else if (cmd.mark && in_range)
        begin
            used_next = cmd.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

    assign bit_out = used_reg;

endmodule

/* design/cfa_row.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfa_row
// The chain of map cells. During a scan the map rotates one unit per cycle,
// so the unit at the output is the address given by the scan counter.
// ----------------------------------------------------------------------------
module cfa_row
    import cfa_pkg::*;
#(
    parameter int MEM_UNITS = DefMemUnits,
    localparam int AW = $clog2(MEM_UNITS)
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfa_row_cmd_t cmd,
    input  logic [AW:0]  rng_lo,
    input  logic [AW+1:0] rng_hi,
    output logic         head_bit
);

    logic [MEM_UNITS-1:0] q;

    genvar g;
    generate
        for (g = 0; g < MEM_UNITS; g++)
        begin : g_cell
            logic in_rng;
            assign in_rng = ((AW+2)'(g) >= {1'b0, rng_lo}) && ((AW+2)'(g) < rng_hi);
            cfa_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cmd      (cmd),
                .in_range (in_rng),
                .shift_in (q[(g + 1) % MEM_UNITS]),
                .bit_out  (q[g])
            );
        end
    endgenerate

    assign head_bit = q[0];

endmodule

/* design/contiguous_fit_allocator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_fit_allocator
// First, best or worst fit placement into a unit-granular free map.
// ----------------------------------------------------------------------------
// The free map is a ring of one-bit cells that rotates once per request
// while the hole tracker watches one unit a cycle. The read state then marks
// or frees the chosen range in all cells at once and loads the result, and
// the done state returns to idle. A stalled result beat holds the read state
// until the result register is free. One request is in flight at a time; the
// result register holds the beat while a new request may already be accepted.
module contiguous_fit_allocator
    import cfa_pkg::*;
#(
    parameter int MEM_UNITS = DefMemUnits,
    localparam int AW = $clog2(MEM_UNITS)
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] proc_name,
    input  logic [7:0] proc_size,
    input  logic [3:0] prior_swaps,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] outcome,
    output logic [7:0] out_name,
    output logic [AW-1:0] out_start,
    output logic [AW:0] out_size,
    output logic [3:0] out_swaps,
    output logic       requeue,
    output logic [AW:0] resident_count,
    output logic [AW-1:0] hole_count,
    output logic [AW:0] used_units
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;
    localparam int EW = 8 + AW + (AW + 1) + 4;
    localparam logic [AW-1:0] LAST_SLOT = AW'(MEM_UNITS - 1);

    logic [1:0]   st_reg, st_next;
    logic [1:0]   pol_reg;
    logic [3:0]   lim_reg;
    logic [7:0]   name_reg;
    logic [7:0]   size_reg;
    logic [3:0]   prior_reg;
    logic [AW:0]  cnt_reg, cnt_next;
    logic [AW:0]  run_len_reg, run_len_next;
    logic [AW-1:0] run_st_reg, run_st_next;
    logic         found_reg, found_next;
    logic [AW-1:0] pk_st_reg, pk_st_next;
    logic [AW:0]  pk_len_reg, pk_len_next;
    logic [AW:0]  holes_reg, holes_next;
    logic [AW:0]  used_reg;
    logic [AW-1:0] head_reg, tail_reg;
    logic [AW:0]  tot_reg;
    logic [EW-1:0] fifo_mem [MEM_UNITS];
    logic [EW-1:0] rd_reg;
    cfa_row_cmd_t cmd;
    logic [AW:0]  rng_lo;
    logic [AW+1:0] rng_hi;
    logic         head_bit;
    logic         rd_en;

    cfa_row #(.MEM_UNITS(MEM_UNITS)) u_row (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rng_lo   (rng_lo),
        .rng_hi   (rng_hi),
        .head_bit (head_bit)
    );

    assign cfg_ready = (st_reg == ST_IDLE);
    assign in_stall  = (st_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pol_reg <= POL_FIRST;
            lim_reg <= SWAP_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_POLICY: pol_reg <= cfg_data[1:0];
                REG_LIMIT:  lim_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Hole tracking: a hole closes at a used unit or at the end of the map.
    logic         sz_ok;
    logic         last_unit;
    logic         close;
    logic [AW:0]  clen;
    logic [AW-1:0] cst;
    logic         take;
    logic         fits;
    logic         ev;
    logic [AW:0]  size_u;

    assign sz_ok = (size_reg != 8'd0) && (int'(size_reg) <= MEM_UNITS);
    assign last_unit = (cnt_reg == (AW+1)'(MEM_UNITS - 1));
    assign size_u = (AW+1)'(size_reg);

    always_comb
    begin
        run_len_next = run_len_reg;
        run_st_next  = run_st_reg;
        close = 1'b0;
        clen  = run_len_reg;
        cst   = run_st_reg;
        if (!head_bit)
        begin
            if (run_len_reg == '0)
            begin
                run_st_next = cnt_reg[AW-1:0];
                cst = cnt_reg[AW-1:0];
            end
            run_len_next = run_len_reg + 1'b1;
            clen = run_len_next;
            if (last_unit)
            begin
                close = 1'b1;
            end
        end
        else
        begin
            close = (run_len_reg != '0);
            run_len_next = '0;
        end
        fits = (int'(clen) >= int'(size_reg));
        case (pol_reg)
            POL_WORST: take = !found_reg || (clen > pk_len_reg);
            POL_BEST:  take = fits && (!found_reg || (clen < pk_len_reg));
            default:   take = !found_reg && fits;
        endcase
        found_next  = found_reg;
        pk_st_next  = pk_st_reg;
        pk_len_next = pk_len_reg;
        holes_next  = holes_reg;
        if (close)
        begin
            holes_next = holes_reg + 1'b1;
            if (take)
            begin
                found_next  = 1'b1;
                pk_st_next  = cst;
                pk_len_next = clen;
            end
        end
    end

    logic load_ok;
    assign load_ok = sz_ok && found_reg && (int'(pk_len_reg) >= int'(size_reg))
                     && (tot_reg < (AW+1)'(MEM_UNITS));
    assign ev = sz_ok && !load_ok && (tot_reg != '0);

    assign rd_en = (st_reg == ST_SCAN) && last_unit;

    // Result decode of the fetched head entry.
    logic [7:0]    e_name;
    logic [AW-1:0] e_start;
    logic [AW:0]   e_size;
    logic [3:0]    e_swaps, e_inc;
    assign {e_name, e_start, e_size, e_swaps} = rd_reg;
    assign e_inc = (e_swaps < SWAP_MAX) ? e_swaps + 4'd1 : SWAP_MAX;

    always_comb
    begin
        cmd = '0;
        rng_lo = '0;
        rng_hi = '0;
        st_next = st_reg;
        cnt_next = cnt_reg;
        case (st_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid) st_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (last_unit) st_next = ST_READ;
            end
            ST_READ:
            begin
                if (!out_valid || !out_stall)
                begin
                    st_next = ST_DONE;
                    cmd.mark = load_ok || ev;
                    cmd.value = load_ok;
                    if (load_ok)
                    begin
                        rng_lo = {1'b0, pk_st_reg};
                        rng_hi = (AW+2)'(pk_st_reg) + (AW+2)'(size_reg);
                    end
                    else
                    begin
                        rng_lo = {1'b0, e_start};
                        rng_hi = (AW+2)'(e_start) + (AW+2)'(e_size);
                    end
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && in_valid)
        begin
            name_reg  <= proc_name;
            size_reg  <= proc_size;
            prior_reg <= prior_swaps;
        end
        if (rd_en)
        begin
            rd_reg <= fifo_mem[head_reg];
        end
        if (st_reg == ST_READ && st_next == ST_DONE && load_ok)
        begin
            fifo_mem[tail_reg] <= {name_reg, pk_st_reg, size_u, prior_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            cnt_reg <= '0;
            run_len_reg <= '0;
            run_st_reg <= '0;
            found_reg <= 1'b0;
            pk_st_reg <= '0;
            pk_len_reg <= '0;
            holes_reg <= '0;
            used_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            tot_reg <= '0;
            out_valid <= 1'b0;
            outcome <= OUT_REJECT;
            out_name <= '0;
            out_start <= '0;
            out_size <= '0;
            out_swaps <= '0;
            requeue <= 1'b0;
            resident_count <= '0;
            hole_count <= '0;
            used_units <= '0;
        end
        else
        begin
            st_reg <= st_next;
            cnt_reg <= cnt_next;
            if (st_reg == ST_IDLE)
            begin
                run_len_reg <= '0;
                found_reg <= 1'b0;
                pk_len_reg <= '0;
                pk_st_reg <= '0;
                holes_reg <= '0;
            end
            else if (st_reg == ST_SCAN)
            begin
                run_len_reg <= run_len_next;
                run_st_reg <= run_st_next;
                found_reg <= found_next;
                pk_st_reg <= pk_st_next;
                pk_len_reg <= pk_len_next;
                holes_reg <= holes_next;
            end
            if (st_reg == ST_READ && st_next == ST_DONE)
            begin
                out_valid <= 1'b1;
                hole_count <= holes_reg[AW-1:0];
                if (load_ok)
                begin
                    outcome <= OUT_LOADED;
                    out_name <= name_reg;
                    out_start <= pk_st_reg;
                    out_size <= size_u;
                    out_swaps <= prior_reg;
                    requeue <= 1'b0;
                    tail_reg <= (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
                    tot_reg <= tot_reg + 1'b1;
                    resident_count <= tot_reg + 1'b1;
                    used_reg <= used_reg + size_u;
                    used_units <= used_reg + size_u;
                end
                else if (ev)
                begin
                    outcome <= OUT_EVICTED;
                    out_name <= e_name;
                    out_start <= e_start;
                    out_size <= e_size;
                    out_swaps <= e_inc;
                    requeue <= (e_inc < lim_reg);
                    head_reg <= (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                    tot_reg <= tot_reg - 1'b1;
                    resident_count <= tot_reg - 1'b1;
                    used_reg <= used_reg - e_size;
                    used_units <= used_reg - e_size;
                end
                else
                begin
                    outcome <= OUT_REJECT;
                    out_name <= name_reg;
                    out_start <= '0;
                    out_size <= '0;
                    out_swaps <= '0;
                    requeue <= 1'b0;
                    resident_count <= tot_reg;
                    used_units <= used_reg;
                end
            end
            else if (out_valid && !out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    property p_no_overfill;
        @(posedge clk) disable iff (!rst_n) tot_reg <= (AW+1)'(MEM_UNITS);
    endproperty
    a_no_overfill: assert property (p_no_overfill) else $error("resident overflow");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= (AW+1)'(MEM_UNITS)) else $error("used units overflow");

    a_result_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_READ && st_next == ST_DONE) |=> out_valid)
        else $error("result missing");

    a_empty_no_used: assert property (@(posedge clk) disable iff (!rst_n)
        (tot_reg == '0) |-> (used_reg == '0)) else $error("used without residents");

endmodule

/* sim/contiguous_fit_allocator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_fit_allocator_tb
// Self-checking bench for the contiguous fit allocator: a directed table of
// requests followed by random request streams (zero and oversize sizes included)
// under every fit policy and several swap limits, with bursty requests and random stalls.
// ----------------------------------------------------------------------------
module contiguous_fit_allocator_tb;
    import cfa_pkg::*;

    localparam int MemUnits = 128;
    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles = 300;

    typedef struct packed {
        logic [1:0] outcome;
        logic [7:0] name;
        logic [6:0] start;
        logic [7:0] size;
        logic [3:0] swaps;
        logic       requeue;
        logic [7:0] residents;
        logic [6:0] holes;
        logic [7:0] used;
    } alloc_result_t;

    typedef struct packed {
        logic [7:0] name;
        logic [6:0] start;
        logic [7:0] size;
        logic [3:0] swaps;
    } resident_t;

    typedef struct {
        logic [7:0] name;
        logic [7:0] size;
        logic [3:0] swaps;
        logic       has_fixed;
        alloc_result_t fixed;
    } request_row_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [3:0] cfg_data;
    logic in_valid;
    logic in_stall;
    logic [7:0] proc_name;
    logic [7:0] proc_size;
    logic [3:0] prior_swaps;
    logic out_valid;
    logic out_stall;
    logic [1:0] outcome;
    logic [7:0] out_name;
    logic [6:0] out_start;
    logic [7:0] out_size;
    logic [3:0] out_swaps;
    logic requeue;
    logic [7:0] resident_count;
    logic [6:0] hole_count;
    logic [7:0] used_units;

    // Shadow allocator state.
    logic      map_used [MemUnits];
    resident_t residents [MemUnits];
    int        res_head;
    int        res_tail;
    int        res_total;
    logic [1:0] policy;
    logic [3:0] limit;

    alloc_result_t pending_results[$];
    int errors;
    int idle_cycles;
    bit stall_mode;

    contiguous_fit_allocator i_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .proc_name(proc_name), .proc_size(proc_size), .prior_swaps(prior_swaps),
        .out_valid(out_valid), .out_stall(out_stall),
        .outcome(outcome), .out_name(out_name), .out_start(out_start),
        .out_size(out_size), .out_swaps(out_swaps), .requeue(requeue),
        .resident_count(resident_count), .hole_count(hole_count),
        .used_units(used_units)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void reset_allocator();
        for (int i = 0; i < MemUnits; i++)
        begin
            map_used[i] = 1'b0;
            residents[i] = '0;
        end
        res_head = 0;
        res_tail = 0;
        res_total = 0;
        policy = POL_FIRST;
        limit = SWAP_LIMIT_RST;
    endfunction

    function automatic alloc_result_t place_request(logic [7:0] name, logic [7:0] size,
                                                    logic [3:0] swaps);
        alloc_result_t r;
        int i;
        int holes;
        bit found;
        int pick_start;
        int pick_len;
        int run_start;
        int run_len;
        int used;
        resident_t victim;
        r = '0;
        r.outcome = OUT_REJECT;
        r.name = name;
        holes = 0;
        found = 0;
        pick_start = 0;
        pick_len = 0;
        i = 0;
        while (i < MemUnits)
        begin
            if (map_used[i])
            begin
                i++;
                continue;
            end
            run_start = i;
            run_len = 0;
            while (i < MemUnits && !map_used[i])
            begin
                run_len++;
                i++;
            end
            holes++;
            if (policy == POL_WORST)
            begin
                if (!found || run_len > pick_len)
                begin
                    found = 1;
                    pick_start = run_start;
                    pick_len = run_len;
                end
            end
            else if (policy == POL_BEST)
            begin
                if (run_len >= size && (!found || run_len < pick_len))
                begin
                    found = 1;
                    pick_start = run_start;
                    pick_len = run_len;
                end
            end
            else if (!found && run_len >= size)
            begin
                found = 1;
                pick_start = run_start;
                pick_len = run_len;
            end
        end
        if (size != 0 && size <= MemUnits)
        begin
            if (found && pick_len >= size && res_total < MemUnits)
            begin
                for (int k = pick_start; k < pick_start + size && k < MemUnits; k++)
                    map_used[k] = 1'b1;
                residents[res_tail] = '{name: name, start: pick_start[6:0],
                                        size: size, swaps: swaps};
                res_tail = (res_tail + 1) % MemUnits;
                res_total++;
                r.outcome = OUT_LOADED;
                r.start = pick_start[6:0];
                r.size = size;
                r.swaps = swaps;
            end
            else if (res_total > 0)
            begin
                victim = residents[res_head];
                res_head = (res_head + 1) % MemUnits;
                res_total--;
                for (int k = victim.start; k < victim.start + victim.size && k < MemUnits; k++)
                    map_used[k] = 1'b0;
                r.swaps = (victim.swaps < SWAP_MAX) ? victim.swaps + 4'd1 : SWAP_MAX;
                r.requeue = (r.swaps >= limit) ? 1'b0 : 1'b1;
                r.outcome = OUT_EVICTED;
                r.name = victim.name;
                r.start = victim.start;
                r.size = victim.size;
            end
        end
        used = 0;
        for (int k = 0; k < MemUnits; k++)
            used += map_used[k];
        r.residents = res_total[7:0];
        r.holes = holes[6:0];
        r.used = used[7:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch in %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // Result checking against the oldest pending expectation.
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected result beat at %0t", $realtime);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (outcome !== want.outcome) report_mismatch("outcome", outcome, want.outcome);
                if (out_name !== want.name) report_mismatch("out_name", out_name, want.name);
                if (out_start !== want.start) report_mismatch("out_start", out_start, want.start);
                if (out_size !== want.size) report_mismatch("out_size", out_size, want.size);
                if (out_swaps !== want.swaps) report_mismatch("out_swaps", out_swaps, want.swaps);
                if (requeue !== want.requeue) report_mismatch("requeue", requeue, want.requeue);
                if (resident_count !== want.residents)
                    report_mismatch("resident_count", resident_count, want.residents);
                if (hole_count !== want.holes) report_mismatch("hole_count", hole_count, want.holes);
                if (used_units !== want.used) report_mismatch("used_units", used_units, want.used);
            end
        end
    end

    // Receiver stall pattern: alternates between stall-free and bursty stretches.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if ($urandom_range(0, 199) == 0)
                stall_mode = ~stall_mode;
            out_stall <= stall_mode ? ($urandom_range(0, 2) == 0) : 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_register(logic index, logic [3:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == REG_POLICY)
            policy = value[1:0];
        else
            limit = value;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (MemUnits + 8) @(posedge clk);
    endtask

    task automatic send_request(logic [7:0] name, logic [7:0] size, logic [3:0] swaps,
                                bit has_fixed, alloc_result_t fixed);
        alloc_result_t want;
        in_valid <= 1'b1;
        proc_name <= name;
        proc_size <= size;
        prior_swaps <= swaps;
        do @(posedge clk); while (in_stall);
        want = place_request(name, size, swaps);
        if (has_fixed && want !== fixed)
        begin
            $display("table row for name %0d disagrees with the predictor", name);
            errors++;
        end
        pending_results.push_back(want);
    endtask

    task automatic random_gap();
        if ($urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    endtask

    request_row_t directed_rows[$];

    task automatic add_row(logic [7:0] name, logic [7:0] size, logic [3:0] swaps,
                           bit has_fixed, alloc_result_t fixed);
        request_row_t row;
        row.name = name;
        row.size = size;
        row.swaps = swaps;
        row.has_fixed = has_fixed;
        row.fixed = fixed;
        directed_rows.push_back(row);
    endtask

    initial
    begin
        alloc_result_t none;
        logic [7:0] name;
        logic [7:0] size;
        int burst;
        none = '0;
        errors = 0;
        stall_mode = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_POLICY;
        cfg_data = '0;
        in_valid = 1'b0;
        proc_name = '0;
        proc_size = '0;
        prior_swaps = '0;
        reset_allocator();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (MemUnits + 8) @(posedge clk);

        // Rejections on an empty map, then a whole-memory load and its eviction.
        add_row(8'd1, 8'd0, 4'd0, 1, '{OUT_REJECT, 8'd1, 7'd0, 8'd0, 4'd0, 1'b0,
                                       8'd0, 7'd1, 8'd0});
        add_row(8'd2, 8'd129, 4'd5, 1, '{OUT_REJECT, 8'd2, 7'd0, 8'd0, 4'd0, 1'b0,
                                         8'd0, 7'd1, 8'd0});
        add_row(8'd3, 8'd255, 4'd15, 1, '{OUT_REJECT, 8'd3, 7'd0, 8'd0, 4'd0, 1'b0,
                                          8'd0, 7'd1, 8'd0});
        add_row(8'hFF, 8'd128, 4'd15, 1, '{OUT_LOADED, 8'hFF, 7'd0, 8'd128, 4'd15, 1'b0,
                                           8'd1, 7'd1, 8'd128});
        add_row(8'd4, 8'd1, 4'd0, 1, '{OUT_EVICTED, 8'hFF, 7'd0, 8'd128, 4'd15, 1'b0,
                                       8'd0, 7'd0, 8'd0});
        // No fit and no resident cannot arise, but a full map with a small request
        // exercises the eviction of a single small resident too.
        add_row(8'd5, 8'd1, 4'd1, 0, none);
        add_row(8'd6, 8'd127, 4'd0, 0, none);
        add_row(8'd7, 8'd2, 4'd14, 0, none);
        add_row(8'd8, 8'd2, 4'd2, 0, none);
        add_row(8'd9, 8'd2, 4'd14, 0, none);
        add_row(8'd10, 8'd60, 4'd0, 0, none);
        add_row(8'd11, 8'd30, 4'd0, 0, none);
        add_row(8'd12, 8'd20, 4'd1, 0, none);
        add_row(8'd13, 8'd10, 4'd7, 0, none);
        add_row(8'd14, 8'd8, 4'd9, 0, none);
        add_row(8'd15, 8'd90, 4'd3, 0, none);

        foreach (directed_rows[i])
            send_request(directed_rows[i].name, directed_rows[i].size,
                         directed_rows[i].swaps, directed_rows[i].has_fixed,
                         directed_rows[i].fixed);
        in_valid <= 1'b0;
        wait_drained();

        // Random phases over policies (the unused code included) and swap limits.
        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0: begin write_register(REG_POLICY, 4'(POL_BEST)); write_register(REG_LIMIT, 4'd1); end
                1: begin write_register(REG_POLICY, 4'(POL_WORST)); write_register(REG_LIMIT, 4'd15); end
                2: begin write_register(REG_POLICY, 4'd3); write_register(REG_LIMIT, 4'd0); end
                3: write_register(REG_POLICY, 4'(POL_FIRST));
                default:
                begin
                    write_register(REG_POLICY, 4'($urandom_range(0, 3)));
                    write_register(REG_LIMIT, 4'($urandom_range(0, 15)));
                end
            endcase
            burst = 0;
            for (int n = 0; n < 155; n++)
            begin
                name = 8'($urandom);
                case ($urandom_range(0, 19))
                    0: size = 8'($urandom);
                    1: size = 8'd0;
                    2: size = 8'($urandom_range(100, 128));
                    default: size = 8'($urandom_range(1, 24));
                endcase
                send_request(name, size, 4'($urandom), 0, none);
                if (n == 70)
                begin
                    // Hold the request side until every result is back.
                    in_valid <= 1'b0;
                    while (pending_results.size() != 0)
                        @(posedge clk);
                end
                else if (burst > 0)
                    burst--;
                else
                begin
                    random_gap();
                    burst = $urandom_range(0, 20);
                end
            end
            in_valid <= 1'b0;
            wait_drained();
        end

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
